// ===== rtl/core/vcfe_pkg.sv =====
// Shared types and codes for the voxel cube frame engine.
// No dependencies; imported by vcfe_exec and voxel_cube_frame_engine.
package vcfe_pkg;

  localparam int unsigned CubeSide = 8;
  localparam int unsigned NumRows  = CubeSide * CubeSide;

  // Command codes
  localparam logic [4:0] FuncFill      = 5'd0;
  localparam logic [4:0] FuncSet       = 5'd1;
  localparam logic [4:0] FuncClear     = 5'd2;
  localparam logic [4:0] FuncRead      = 5'd3;
  localparam logic [4:0] FuncDraw      = 5'd4;
  localparam logic [4:0] FuncErase     = 5'd5;
  localparam logic [4:0] FuncRotFirst  = 5'd6;
  localparam logic [4:0] FuncRotLast   = 5'd11;
  localparam logic [4:0] FuncShfFirst  = 5'd12;
  localparam logic [4:0] FuncShfLast   = 5'd17;
  localparam logic [4:0] FuncScan      = 5'd18;

  // Status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StNoFit = 2'd2;
  localparam logic [1:0] StSmall = 2'd3;

  // Move directions for rotate and shift-insert
  typedef enum logic [2:0] {
    DirDown  = 3'd0,
    DirUp    = 3'd1,
    DirFront = 3'd2,
    DirBack  = 3'd3,
    DirRight = 3'd4,
    DirLeft  = 3'd5
  } dir_e;

  typedef logic [NumRows-1:0][7:0] frame_t;

  typedef struct packed {
    logic [4:0]  func;
    logic [2:0]  coord_x;
    logic [2:0]  coord_y;
    logic [2:0]  coord_z;
    logic [3:0]  cube_size;
    logic [7:0]  fill_value;
    logic [63:0] plane_bits;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        voxel_value;
    logic [2:0]  layer_index;
    logic [63:0] layer_data;
  } res_t;

endpackage

// ===== rtl/core/vcfe_exec.sv =====
// Single-pass command datapath: next frame, next scan layer and result beat.
// Depends on vcfe_pkg.
module vcfe_exec (
  input  vcfe_pkg::cmd_t     cmd_i,
  input  vcfe_pkg::frame_t   frame_i,
  input  logic [2:0]         scan_i,
  output vcfe_pkg::frame_t   frame_o,
  output logic [2:0]         scan_o,
  output vcfe_pkg::res_t     res_o
);
  import vcfe_pkg::*;

  logic        is_rot, is_shf;
  dir_e        dir;
  logic [63:0] edge_p, ins_p;
  logic [3:0]  t;
  logic [2:0]  zt, yt;
  logic        fits, too_small;
  logic [15:0] full16, border16;
  logic [7:0]  full_m, border_m;

  always_comb begin
    is_rot = cmd_i.func inside {[FuncRotFirst:FuncRotLast]};
    is_shf = cmd_i.func inside {[FuncShfFirst:FuncShfLast]};
    if (is_rot) begin
      dir = dir_e'(3'(cmd_i.func - FuncRotFirst));
    end else begin
      dir = dir_e'(3'(cmd_i.func - FuncShfFirst));
    end
  end

  // Face that leaves the frame; re-enters on the far side for a rotate
  always_comb begin
    edge_p = '0;
    for (int k = 0; k < CubeSide; k++) begin
      case (dir)
        DirDown:  edge_p[8*k +: 8] = frame_i[8*(CubeSide-1) + k];
        DirUp:    edge_p[8*k +: 8] = frame_i[k];
        DirFront: edge_p[8*k +: 8] = frame_i[8*k + CubeSide - 1];
        DirBack:  edge_p[8*k +: 8] = frame_i[8*k];
        DirRight: begin
          for (int j = 0; j < CubeSide; j++) edge_p[8*k + j] = frame_i[8*k + j][0];
        end
        default: begin
          for (int j = 0; j < CubeSide; j++) edge_p[8*k + j] = frame_i[8*k + j][7];
        end
      endcase
    end
    ins_p = is_rot ? edge_p : cmd_i.plane_bits;
  end

  // Wireframe cube geometry
  always_comb begin
    t         = cmd_i.cube_size - 4'd1;
    too_small = cmd_i.cube_size < 4'd2;
    fits      = ({2'b0, cmd_i.coord_x} + {1'b0, t} <= 5'd7) &&
                ({2'b0, cmd_i.coord_y} + {1'b0, t} <= 5'd7) &&
                ({2'b0, cmd_i.coord_z} + {1'b0, t} <= 5'd7);
    zt        = 3'(cmd_i.coord_z + t[2:0]);
    yt        = 3'(cmd_i.coord_y + t[2:0]);
    full16    = ((16'd1 << ({1'b0, t} + 5'd1)) - 16'd1) << cmd_i.coord_x;
    border16  = (16'd1 | (16'd1 << t)) << cmd_i.coord_x;
    full_m    = full16[7:0];
    border_m  = border16[7:0];
  end

  always_comb begin
    logic       zedge, yedge, zin, yin;
    logic [7:0] mask;
    logic [2:0] zz3, yy3;
    int         r;

    frame_o = frame_i;
    scan_o  = scan_i;
    res_o   = '0;
    zedge   = 1'b0;
    yedge   = 1'b0;
    zin     = 1'b0;
    yin     = 1'b0;
    mask    = '0;
    zz3     = '0;
    yy3     = '0;
    r       = 0;

    if (is_rot || is_shf) begin
      for (int zz = 0; zz < CubeSide; zz++) begin
        for (int yy = 0; yy < CubeSide; yy++) begin
          r = 8*zz + yy;
          case (dir)
            DirDown:  frame_o[r] = (zz != 0) ? frame_i[(r + 56) & 63] : ins_p[8*yy +: 8];
            DirUp:    frame_o[r] = (zz != CubeSide - 1) ? frame_i[(r + 8) & 63]
                                                        : ins_p[8*yy +: 8];
            DirFront: frame_o[r] = (yy != 0) ? frame_i[8*zz + ((yy + 7) & 7)]
                                             : ins_p[8*zz +: 8];
            DirBack:  frame_o[r] = (yy != CubeSide - 1) ? frame_i[8*zz + ((yy + 1) & 7)]
                                                        : ins_p[8*zz +: 8];
            DirRight: frame_o[r] = {ins_p[r], frame_i[r][7:1]};
            default:  frame_o[r] = {frame_i[r][6:0], ins_p[r]};
          endcase
        end
      end
    end else begin
      case (cmd_i.func)
        FuncFill: begin
          for (int k = 0; k < NumRows; k++) frame_o[k] = cmd_i.fill_value;
        end
        FuncSet:   frame_o[{cmd_i.coord_z, cmd_i.coord_y}][cmd_i.coord_x] = 1'b1;
        FuncClear: frame_o[{cmd_i.coord_z, cmd_i.coord_y}][cmd_i.coord_x] = 1'b0;
        FuncRead:  res_o.voxel_value =
                     frame_i[{cmd_i.coord_z, cmd_i.coord_y}][cmd_i.coord_x];
        FuncDraw, FuncErase: begin
          if (too_small) begin
            res_o.status = StSmall;
          end else if (!fits) begin
            res_o.status = StNoFit;
          end else begin
            for (int zz = 0; zz < CubeSide; zz++) begin
              for (int yy = 0; yy < CubeSide; yy++) begin
                r     = 8*zz + yy;
                zz3   = 3'(zz);
                yy3   = 3'(yy);
                zedge = (zz3 == cmd_i.coord_z) || (zz3 == zt);
                yedge = (yy3 == cmd_i.coord_y) || (yy3 == yt);
                zin   = (zz3 >= cmd_i.coord_z) && (zz3 <= zt);
                yin   = (yy3 >= cmd_i.coord_y) && (yy3 <= yt);
                if (zedge && yedge) begin
                  mask = full_m;
                end else if ((zedge && yin) || (yedge && zin)) begin
                  mask = border_m;
                end else begin
                  mask = '0;
                end
                if (cmd_i.func == FuncErase) begin
                  frame_o[r] = frame_i[r] & ~mask;
                end else begin
                  frame_o[r] = frame_i[r] | mask;
                end
              end
            end
          end
        end
        FuncScan: begin
          // Advance the layer first, then read it
          scan_o            = scan_i + 3'd1;
          res_o.layer_index = scan_o;
          for (int k = 0; k < CubeSide; k++) begin
            res_o.layer_data[8*k +: 8] = frame_i[{scan_o, 3'(k)}];
          end
        end
        default: res_o.status = StRange;
      endcase
    end
  end

endmodule

// ===== rtl/core/voxel_cube_frame_engine.sv =====
// Voxel cube frame engine top level: command register, frame store, result register.
// Depends on vcfe_pkg and vcfe_exec.
//
// One command is accepted on every clock edge at which start is high; busy is
// never raised. Each command yields exactly one result beat, shown on result_o
// for a single cycle with done_o high: the accepting edge loads the command
// register, and the result register is then loaded from it through the
// datapath. The 8x8x8 frame is held in flip-flops and every command computes
// all 64 rows of the next frame in that single datapath pass, so the rate is
// one command per cycle. The receiver cannot stall: a beat not taken in its
// cycle is gone.
module voxel_cube_frame_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  vcfe_pkg::cmd_t cmd_i,
  output logic           done_o,
  output vcfe_pkg::res_t result_o
);
  import vcfe_pkg::*;

  cmd_t       cmd_q;
  logic       cmd_vld_q;
  frame_t     frame_q, frame_d;
  logic [2:0] scan_q, scan_d;
  res_t       res_q, res_d;
  logic       done_q;

  assign busy = 1'b0;

  vcfe_exec u_exec (
    .cmd_i   (cmd_q),
    .frame_i (frame_q),
    .scan_i  (scan_q),
    .frame_o (frame_d),
    .scan_o  (scan_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      frame_q   <= '0;
      scan_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      cmd_vld_q <= start && !busy;
      done_q    <= cmd_vld_q;
      if (cmd_vld_q) begin
        frame_q <= frame_d;
        scan_q  <= scan_d;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
    if (cmd_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
